[hw/rtl/ompar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ompar_pkg
// Shared types, codes and constants of the order message stream parser.
// ----------------------------------------------------------------------------
package ompar_pkg;

   localparam int HEADER_BYTES = 2;

   // queue depths between the stages and at the result side
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_CANCEL  = 3'd1;
   localparam logic [2:0] KIND_EXECUTE = 3'd2;
   localparam logic [2:0] KIND_DELETE  = 3'd3;
   localparam logic [2:0] KIND_REPLACE = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;

   localparam logic [7:0] TYPE_ADD     = 8'h41; // 'A'
   localparam logic [7:0] TYPE_CANCEL  = 8'h58; // 'X'
   localparam logic [7:0] TYPE_EXECUTE = 8'h45; // 'E'
   localparam logic [7:0] TYPE_DELETE  = 8'h44; // 'D'
   localparam logic [7:0] TYPE_REPLACE = 8'h52; // 'R'
   localparam logic [7:0] SIDE_BUY     = 8'h42; // 'B'
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   localparam logic [15:0] LEN_ADD     = 16'd36;
   localparam logic [15:0] LEN_CANCEL  = 16'd23;
   localparam logic [15:0] LEN_EXECUTE = 16'd31;
   localparam logic [15:0] LEN_DELETE  = 16'd19;
   localparam logic [15:0] LEN_REPLACE = 16'd35;

   typedef enum logic [2:0] {
      FIELD_NONE,
      FIELD_STAMP,
      FIELD_ORDER,
      FIELD_SIDE,
      FIELD_QTY,
      FIELD_SYMBOL,
      FIELD_PRICE
   } field_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  message_kind;
      logic [1:0]  status;
      logic [47:0] stamp_ns;
      logic [63:0] order_ref;
      logic        buy_side;
      logic [31:0] quantity;
      logic [31:0] raw_price;
      logic [63:0] symbol_chars;
   } rsp_item_type;

   // classified byte handed from the front to the back
   typedef struct packed {
      logic [7:0] data_byte;
      field_type  field;
      logic       clear;
      logic       emit;
      logic [2:0] kind;
      logic [1:0] status;
   } cmd_type;

   function automatic logic [15:0] need_length(input logic [2:0] kind);
      logic [15:0] len;
      case (kind)
         KIND_ADD:     len = LEN_ADD;
         KIND_CANCEL:  len = LEN_CANCEL;
         KIND_EXECUTE: len = LEN_EXECUTE;
         KIND_DELETE:  len = LEN_DELETE;
         KIND_REPLACE: len = LEN_REPLACE;
         default:      len = LEN_ADD;
      endcase
      return len;
   endfunction

endpackage

[hw/rtl/ompar_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ompar_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ompar_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hw/rtl/ompar_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ompar_front
// Tracks header, type and body position of the byte stream and classifies
// each byte into a command for the field collector.
// ----------------------------------------------------------------------------
module ompar_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  ompar_pkg::req_item_type req_data,
   output logic                   cmd_push,
   input  logic                   cmd_full,
   output ompar_pkg::cmd_type     cmd_data
);

   localparam logic [15:0] OFS_STAMP_LO  = 16'd5;
   localparam logic [15:0] OFS_STAMP_HI  = 16'd10;
   localparam logic [15:0] OFS_ORDER_LO  = 16'd11;
   localparam logic [15:0] OFS_ORDER_HI  = 16'd18;
   localparam logic [15:0] OFS_A_SIDE    = 16'd19;
   localparam logic [15:0] OFS_A_QTY_LO  = 16'd20;
   localparam logic [15:0] OFS_A_QTY_HI  = 16'd23;
   localparam logic [15:0] OFS_A_SYM_LO  = 16'd24;
   localparam logic [15:0] OFS_A_SYM_HI  = 16'd31;
   localparam logic [15:0] OFS_A_PRC_LO  = 16'd32;
   localparam logic [15:0] OFS_A_PRC_HI  = 16'd35;
   localparam logic [15:0] OFS_X_QTY_LO  = 16'd19;
   localparam logic [15:0] OFS_X_QTY_HI  = 16'd22;
   localparam logic [15:0] OFS_R_QTY_LO  = 16'd27;
   localparam logic [15:0] OFS_R_QTY_HI  = 16'd30;
   localparam logic [15:0] OFS_R_PRC_LO  = 16'd31;
   localparam logic [15:0] OFS_R_PRC_HI  = 16'd34;

   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] index_ff, index_in;
   logic [2:0]  kind_ff, kind_in;
   logic        discard_ff, discard_in;

   logic                 accept;
   logic                 type_known;
   logic [2:0]           type_kind;
   ompar_pkg::field_type body_field;
   logic                 body_last;

   assign req_full  = cmd_full;
   assign accept    = req_push & ~cmd_full;
   assign body_last = (index_ff == length_ff - 16'd1);

   always_comb begin
      type_known = 1'b1;
      case (req_data.data_byte)
         ompar_pkg::TYPE_ADD:     type_kind = ompar_pkg::KIND_ADD;
         ompar_pkg::TYPE_CANCEL:  type_kind = ompar_pkg::KIND_CANCEL;
         ompar_pkg::TYPE_EXECUTE: type_kind = ompar_pkg::KIND_EXECUTE;
         ompar_pkg::TYPE_DELETE:  type_kind = ompar_pkg::KIND_DELETE;
         ompar_pkg::TYPE_REPLACE: type_kind = ompar_pkg::KIND_REPLACE;
         default: begin
            type_kind  = ompar_pkg::KIND_ADD;
            type_known = 1'b0;
         end
      endcase
   end

   // field layout by body offset; the common fields come first for every type
   always_comb begin
      body_field = ompar_pkg::FIELD_NONE;
      if (index_ff >= OFS_STAMP_LO && index_ff <= OFS_STAMP_HI) begin
         body_field = ompar_pkg::FIELD_STAMP;
      end else if (index_ff >= OFS_ORDER_LO && index_ff <= OFS_ORDER_HI) begin
         body_field = ompar_pkg::FIELD_ORDER;
      end else begin
         case (kind_ff)
            ompar_pkg::KIND_ADD: begin
               if (index_ff == OFS_A_SIDE) begin
                  body_field = ompar_pkg::FIELD_SIDE;
               end else if (index_ff >= OFS_A_QTY_LO && index_ff <= OFS_A_QTY_HI) begin
                  body_field = ompar_pkg::FIELD_QTY;
               end else if (index_ff >= OFS_A_SYM_LO && index_ff <= OFS_A_SYM_HI) begin
                  body_field = ompar_pkg::FIELD_SYMBOL;
               end else if (index_ff >= OFS_A_PRC_LO && index_ff <= OFS_A_PRC_HI) begin
                  body_field = ompar_pkg::FIELD_PRICE;
               end
            end
            ompar_pkg::KIND_CANCEL, ompar_pkg::KIND_EXECUTE: begin
               if (index_ff >= OFS_X_QTY_LO && index_ff <= OFS_X_QTY_HI) begin
                  body_field = ompar_pkg::FIELD_QTY;
               end
            end
            ompar_pkg::KIND_REPLACE: begin
               if (index_ff >= OFS_R_QTY_LO && index_ff <= OFS_R_QTY_HI) begin
                  body_field = ompar_pkg::FIELD_QTY;
               end else if (index_ff >= OFS_R_PRC_LO && index_ff <= OFS_R_PRC_HI) begin
                  body_field = ompar_pkg::FIELD_PRICE;
               end
            end
            default: body_field = ompar_pkg::FIELD_NONE;
         endcase
      end
   end

   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      length_in  = length_ff;
      index_in   = index_ff;
      kind_in    = kind_ff;
      discard_in = discard_ff;

      cmd_push           = 1'b0;
      cmd_data.data_byte = req_data.data_byte;
      cmd_data.field     = ompar_pkg::FIELD_NONE;
      cmd_data.clear     = 1'b0;
      cmd_data.emit      = 1'b0;
      cmd_data.kind      = kind_ff;
      cmd_data.status    = ompar_pkg::STATUS_OK;

      if (accept && !discard_ff) begin
         if (hdr_cnt_ff < 2'(ompar_pkg::HEADER_BYTES)) begin
            length_in  = {length_ff[7:0], req_data.data_byte};
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
         end else if (index_ff == '0) begin
            // type byte: clear the collector, flag errors at once
            cmd_push       = 1'b1;
            cmd_data.clear = 1'b1;
            cmd_data.kind  = type_kind;
            if (!type_known) begin
               cmd_data.emit   = 1'b1;
               cmd_data.status = ompar_pkg::STATUS_UNKNOWN;
               discard_in      = 1'b1;
            end else if (length_ff < ompar_pkg::need_length(type_kind)) begin
               cmd_data.emit   = 1'b1;
               cmd_data.status = ompar_pkg::STATUS_SHORT;
               discard_in      = 1'b1;
            end else begin
               kind_in  = type_kind;
               index_in = index_ff + 16'd1;
            end
         end else begin
            cmd_data.field = body_field;
            cmd_data.emit  = body_last;
            cmd_push       = (body_field != ompar_pkg::FIELD_NONE) || body_last;
            if (body_last) begin
               hdr_cnt_in = '0;
               length_in  = '0;
               index_in   = '0;
            end else begin
               index_in = index_ff + 16'd1;
            end
         end
      end

      if (accept && req_data.end_of_buffer) begin
         hdr_cnt_in = '0;
         length_in  = '0;
         index_in   = '0;
         kind_in    = ompar_pkg::KIND_ADD;
         discard_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff <= '0;
         length_ff  <= '0;
         index_ff   <= '0;
         kind_ff    <= ompar_pkg::KIND_ADD;
         discard_ff <= 1'b0;
      end else begin
         hdr_cnt_ff <= hdr_cnt_in;
         length_ff  <= length_in;
         index_ff   <= index_in;
         kind_ff    <= kind_in;
         discard_ff <= discard_in;
      end
   end

endmodule

[hw/rtl/ompar_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ompar_back
// Collects big-endian fields from classified bytes and builds the result
// item when a message completes or fails.
// ----------------------------------------------------------------------------
module ompar_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_empty,
   output logic                    cmd_pop,
   input  ompar_pkg::cmd_type      cmd_data,
   output logic                    rsp_push,
   input  logic                    rsp_full,
   output ompar_pkg::rsp_item_type rsp_data
);

   logic [47:0] stamp_ff, stamp_in;
   logic [63:0] order_ff, order_in;
   logic        side_ff, side_in;
   logic [31:0] qty_ff, qty_in;
   logic [31:0] price_ff, price_in;
   logic [63:0] symbol_ff, symbol_in;

   // zero trailing spaces, scanning up from the last symbol byte
   function automatic logic [63:0] trim_symbol(input logic [63:0] sym);
      logic [63:0] s;
      logic        run;
      s   = sym;
      run = 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (run && s[8*k +: 8] == ompar_pkg::CHAR_SPACE) begin
            s[8*k +: 8] = 8'h00;
         end else begin
            run = 1'b0;
         end
      end
      return s;
   endfunction

   // hold the command while a result has nowhere to go
   assign cmd_pop  = ~cmd_empty & (~cmd_data.emit | ~rsp_full);
   assign rsp_push = cmd_pop & cmd_data.emit;

   always_comb begin
      stamp_in  = stamp_ff;
      order_in  = order_ff;
      side_in   = side_ff;
      qty_in    = qty_ff;
      price_in  = price_ff;
      symbol_in = symbol_ff;
      if (cmd_data.clear) begin
         stamp_in  = '0;
         order_in  = '0;
         side_in   = 1'b0;
         qty_in    = '0;
         price_in  = '0;
         symbol_in = '0;
      end
      case (cmd_data.field)
         ompar_pkg::FIELD_STAMP:  stamp_in  = {stamp_ff[39:0], cmd_data.data_byte};
         ompar_pkg::FIELD_ORDER:  order_in  = {order_ff[55:0], cmd_data.data_byte};
         ompar_pkg::FIELD_SIDE:   side_in   = (cmd_data.data_byte == ompar_pkg::SIDE_BUY);
         ompar_pkg::FIELD_QTY:    qty_in    = {qty_ff[23:0], cmd_data.data_byte};
         ompar_pkg::FIELD_SYMBOL: symbol_in = {symbol_ff[55:0], cmd_data.data_byte};
         ompar_pkg::FIELD_PRICE:  price_in  = {price_ff[23:0], cmd_data.data_byte};
         default: ;
      endcase
   end

   always_comb begin
      rsp_data.message_kind = cmd_data.kind;
      rsp_data.status       = cmd_data.status;
      rsp_data.stamp_ns     = '0;
      rsp_data.order_ref    = '0;
      rsp_data.buy_side     = 1'b0;
      rsp_data.quantity     = '0;
      rsp_data.raw_price    = '0;
      rsp_data.symbol_chars = '0;
      if (cmd_data.status == ompar_pkg::STATUS_OK) begin
         rsp_data.stamp_ns     = stamp_in;
         rsp_data.order_ref    = order_in;
         rsp_data.buy_side     = side_in;
         rsp_data.quantity     = qty_in;
         rsp_data.raw_price    = price_in;
         rsp_data.symbol_chars = trim_symbol(symbol_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         stamp_ff  <= stamp_in;
         order_ff  <= order_in;
         side_ff   <= side_in;
         qty_ff    <= qty_in;
         price_ff  <= price_in;
         symbol_ff <= symbol_in;
      end
   end

   property p_no_emit_into_full;
      @(posedge clock) disable iff (reset)
         (!cmd_empty && cmd_data.emit && rsp_full) |-> !cmd_pop;
   endproperty
   assert property (p_no_emit_into_full)
      else $error("result transfer issued into a full queue");

endmodule

[hw/rtl/order_message_stream_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_message_stream_parser
// Byte-stream parser for length-prefixed market order messages.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive req_data (one stream byte plus end-of-buffer
//   flag) and req_push; a byte transfers on a clock edge with req_push high
//   and req_full low. Result queue side: while rsp_empty is low the oldest
//   result sits on rsp_data; raise rsp_pop to transfer it.
//   One byte per cycle is accepted sustained while req_full stays low. The
//   front tracks header, type and offset of each byte and passes classified
//   bytes through a short command queue to the back, which collects the
//   fields and writes the result of the byte that completes or fails its
//   message into the result queue, from where it is shown on rsp_data.
//   Reset (synchronous) empties both queues and returns the parser to the
//   start of a message header. When the receiver stalls, results wait in
//   the result queue; once it fills, the back holds its command, the
//   command queue fills and req_full rises. Bytes that produce no command
//   (header, skipped and discarded bytes) still need a free command slot.
// ----------------------------------------------------------------------------
module order_message_stream_parser #(
   parameter int CMD_DEPTH = ompar_pkg::CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = ompar_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  ompar_pkg::req_item_type req_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output ompar_pkg::rsp_item_type rsp_data
);

   localparam int CMD_W = $bits(ompar_pkg::cmd_type);
   localparam int RSP_W = $bits(ompar_pkg::rsp_item_type);

   ompar_pkg::cmd_type      front_cmd;
   ompar_pkg::cmd_type      back_cmd;
   logic                    front_push;
   logic                    cmd_full;
   logic                    cmd_empty;
   logic                    cmd_pop;
   logic                    back_push;
   logic                    rsp_full;
   ompar_pkg::rsp_item_type back_rsp;

   ompar_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (front_push),
      .cmd_full (cmd_full),
      .cmd_data (front_cmd)
   );

   ompar_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .full    (cmd_full),
      .wr_data (front_cmd),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (back_cmd)
   );

   ompar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (back_cmd),
      .rsp_push  (back_push),
      .rsp_full  (rsp_full),
      .rsp_data  (back_rsp)
   );

   ompar_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .full    (rsp_full),
      .wr_data (back_rsp),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_data)
   );

   property p_error_has_no_fields;
      @(posedge clock) disable iff (reset)
         (!rsp_empty && rsp_data.status != ompar_pkg::STATUS_OK) |->
            (rsp_data.stamp_ns == '0 && rsp_data.order_ref == '0 &&
             rsp_data.quantity == '0 && rsp_data.raw_price == '0 &&
             rsp_data.symbol_chars == '0 && !rsp_data.buy_side);
   endproperty
   assert property (p_error_has_no_fields)
      else $error("error result carries field data");

   property p_unknown_reports_add_kind;
      @(posedge clock) disable iff (reset)
         (!rsp_empty && rsp_data.status == ompar_pkg::STATUS_UNKNOWN) |->
            (rsp_data.message_kind == ompar_pkg::KIND_ADD);
   endproperty
   assert property (p_unknown_reports_add_kind)
      else $error("unknown-type result with nonzero kind");

   property p_add_only_fields;
      @(posedge clock) disable iff (reset)
         (!rsp_empty && rsp_data.message_kind != ompar_pkg::KIND_ADD) |->
            (!rsp_data.buy_side && rsp_data.symbol_chars == '0);
   endproperty
   assert property (p_add_only_fields)
      else $error("side or symbol set on a non-add result");

   property p_result_codes_legal;
      @(posedge clock) disable iff (reset)
         !rsp_empty |-> (rsp_data.message_kind <= ompar_pkg::KIND_REPLACE &&
                         rsp_data.status <= ompar_pkg::STATUS_SHORT);
   endproperty
   assert property (p_result_codes_legal)
      else $error("result kind or status code out of range");

endmodule

[sim/order_message_stream_parser_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_message_stream_parser_test
// Self-checking bench for the order message stream parser: a short table of
// edge cases, then random length-prefixed messages with broken and truncated
// ones mixed in, checked field by field against a cycle-free parser model.
// ----------------------------------------------------------------------------
module order_message_stream_parser_test;

   localparam int ITEM_TARGET   = 1950;
   localparam int HOLD_AT_POP   = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 2000;

   localparam logic [7:0] TYPE_UNKNOWN = 8'h51; // 'Q'
   localparam logic [7:0] SIDE_SELL    = 8'h53; // 'S'

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [2:0] kind;
      logic [1:0] status;
   } table_row_type;

   localparam int TABLE_ROWS = 26;
   localparam table_row_type STIMULUS_TABLE [TABLE_ROWS] = '{
      // unknown type byte, rest of the buffer discarded
      '{8'h00, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h24, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{TYPE_UNKNOWN, 1'b0, 1'b1, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_UNKNOWN},
      '{8'hFF, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h00, 1'b1, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      // zero length, buffer ends on the type byte
      '{8'h00, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{ompar_pkg::TYPE_ADD, 1'b1, 1'b1, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_SHORT},
      // one byte short of the replace, cancel, execute and delete types
      '{8'h00, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h22, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{ompar_pkg::TYPE_REPLACE, 1'b0, 1'b1, ompar_pkg::KIND_REPLACE,
        ompar_pkg::STATUS_SHORT},
      '{ompar_pkg::TYPE_ADD, 1'b1, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h16, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{ompar_pkg::TYPE_CANCEL, 1'b1, 1'b1, ompar_pkg::KIND_CANCEL,
        ompar_pkg::STATUS_SHORT},
      '{8'h00, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h1E, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{ompar_pkg::TYPE_EXECUTE, 1'b1, 1'b1, ompar_pkg::KIND_EXECUTE,
        ompar_pkg::STATUS_SHORT},
      '{8'h00, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'h12, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{ompar_pkg::TYPE_DELETE, 1'b1, 1'b1, ompar_pkg::KIND_DELETE,
        ompar_pkg::STATUS_SHORT},
      // largest length cut off by end of buffer: dropped
      '{8'hFF, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{ompar_pkg::TYPE_CANCEL, 1'b0, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      '{8'hFF, 1'b1, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK},
      // end of buffer inside the header
      '{8'h12, 1'b1, 1'b0, ompar_pkg::KIND_ADD, ompar_pkg::STATUS_OK}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   ompar_pkg::req_item_type req_data = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   ompar_pkg::rsp_item_type rsp_data;

   // parser model state
   logic [1:0]  hdr_count = '0;
   logic [15:0] msg_length = '0;
   logic [15:0] body_pos = '0;
   logic [2:0]  cur_kind = '0;
   logic [47:0] stamp = '0;
   logic [63:0] order = '0;
   logic        side = 1'b0;
   logic [31:0] qty = '0;
   logic [31:0] price = '0;
   logic [63:0] symbol = '0;
   logic        skipping = 1'b0;

   ompar_pkg::rsp_item_type expected_messages[$];
   int                      fail_count = 0;
   int                      byte_count = 0;
   int                      stall_cycles = 0;
   bit                      sender_rush = 1'b0;

   order_message_stream_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int kind_of_type(input logic [7:0] b);
      case (b)
         ompar_pkg::TYPE_ADD:     return int'(ompar_pkg::KIND_ADD);
         ompar_pkg::TYPE_CANCEL:  return int'(ompar_pkg::KIND_CANCEL);
         ompar_pkg::TYPE_EXECUTE: return int'(ompar_pkg::KIND_EXECUTE);
         ompar_pkg::TYPE_DELETE:  return int'(ompar_pkg::KIND_DELETE);
         ompar_pkg::TYPE_REPLACE: return int'(ompar_pkg::KIND_REPLACE);
         default:                 return -1;
      endcase
   endfunction

   function automatic logic [15:0] min_body_length(input logic [2:0] kind);
      case (kind)
         ompar_pkg::KIND_ADD:     return ompar_pkg::LEN_ADD;
         ompar_pkg::KIND_CANCEL:  return ompar_pkg::LEN_CANCEL;
         ompar_pkg::KIND_EXECUTE: return ompar_pkg::LEN_EXECUTE;
         ompar_pkg::KIND_DELETE:  return ompar_pkg::LEN_DELETE;
         default:                 return ompar_pkg::LEN_REPLACE;
      endcase
   endfunction

   function automatic logic [63:0] strip_trailing_spaces(input logic [63:0] s);
      int k;
      for (k = 0; k < 8; k++) begin
         if (s[8*k +: 8] != ompar_pkg::CHAR_SPACE) break;
         s[8*k +: 8] = 8'h00;
      end
      return s;
   endfunction

   task automatic clear_fields();
      stamp = '0;
      order = '0;
      side = 1'b0;
      qty = '0;
      price = '0;
      symbol = '0;
   endtask

   task automatic collect_field(input logic [15:0] i, input logic [7:0] b);
      if (i >= 5 && i < 11) stamp = {stamp[39:0], b};
      if (i >= 11 && i < 19) order = {order[55:0], b};
      case (cur_kind)
         ompar_pkg::KIND_ADD: begin
            if (i == 19) side = (b == ompar_pkg::SIDE_BUY);
            if (i >= 20 && i < 24) qty = {qty[23:0], b};
            if (i >= 24 && i < 32) symbol = {symbol[55:0], b};
            if (i >= 32 && i < 36) price = {price[23:0], b};
         end
         ompar_pkg::KIND_CANCEL, ompar_pkg::KIND_EXECUTE: begin
            if (i >= 19 && i < 23) qty = {qty[23:0], b};
         end
         ompar_pkg::KIND_REPLACE: begin
            if (i >= 27 && i < 31) qty = {qty[23:0], b};
            if (i >= 31 && i < 35) price = {price[23:0], b};
         end
         default: ;
      endcase
   endtask

   // advance the parser model by one stream byte
   task automatic parse_stream_byte(input logic [7:0] b, input logic last,
                                    output bit produced,
                                    output ompar_pkg::rsp_item_type msg);
      int k;
      produced = 1'b0;
      msg = '0;
      if (!skipping) begin
         if (hdr_count < ompar_pkg::HEADER_BYTES) begin
            msg_length = {msg_length[7:0], b};
            hdr_count = hdr_count + 2'd1;
         end else begin
            if (body_pos == 0) begin
               k = kind_of_type(b);
               clear_fields();
               if (k < 0) begin
                  msg.message_kind = ompar_pkg::KIND_ADD;
                  msg.status = ompar_pkg::STATUS_UNKNOWN;
                  produced = 1'b1;
                  skipping = 1'b1;
               end else if (msg_length < min_body_length(3'(k))) begin
                  msg.message_kind = 3'(k);
                  msg.status = ompar_pkg::STATUS_SHORT;
                  produced = 1'b1;
                  skipping = 1'b1;
               end else begin
                  cur_kind = 3'(k);
               end
            end else begin
               collect_field(body_pos, b);
            end
            if (!skipping) begin
               if (msg_length != 0 && body_pos == msg_length - 16'd1) begin
                  msg.message_kind = cur_kind;
                  msg.status = ompar_pkg::STATUS_OK;
                  msg.stamp_ns = stamp;
                  msg.order_ref = order;
                  msg.buy_side = side;
                  msg.quantity = qty;
                  msg.raw_price = price;
                  msg.symbol_chars = strip_trailing_spaces(symbol);
                  produced = 1'b1;
                  hdr_count = '0;
                  msg_length = '0;
                  body_pos = '0;
               end else begin
                  body_pos = body_pos + 16'd1;
               end
            end
         end
      end
      if (last) begin
         hdr_count = '0;
         msg_length = '0;
         body_pos = '0;
         cur_kind = '0;
         skipping = 1'b0;
         clear_fields();
      end
   endtask

   task automatic send_stream_byte(input logic [7:0] value, input logic last,
                                   input logic typed,
                                   input ompar_pkg::rsp_item_type typed_msg);
      int                      gap;
      bit                      produced;
      ompar_pkg::rsp_item_type msg;
      gap = sender_rush ? 0 : int'($urandom_range(0, 3));
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{data_byte: value, end_of_buffer: last};
      do @(posedge clock); while (req_full);
      parse_stream_byte(value, last, produced, msg);
      byte_count++;
      if (typed) begin
         expected_messages.insert(expected_messages.size(), typed_msg);
      end else if (produced) begin
         expected_messages.insert(expected_messages.size(), msg);
      end
   endtask

   // hold the input until every expected result has been transferred
   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_messages.size() != 0);
   endtask

   task automatic send_random_message();
      int          roll;
      int          kind_pick;
      int          fill;
      int          spaces;
      int          noise;
      int          i;
      bit          broken;
      logic [7:0]  type_byte;
      logic [15:0] need;
      logic [15:0] length;
      logic [7:0]  body[$];
      logic [8:0]  chunk[$];
      roll = int'($urandom_range(0, 99));
      kind_pick = int'($urandom_range(0, 4));
      sender_rush = ($urandom_range(0, 3) == 0);
      broken = 1'b0;
      case (kind_pick)
         0:       type_byte = ompar_pkg::TYPE_ADD;
         1:       type_byte = ompar_pkg::TYPE_CANCEL;
         2:       type_byte = ompar_pkg::TYPE_EXECUTE;
         3:       type_byte = ompar_pkg::TYPE_DELETE;
         default: type_byte = ompar_pkg::TYPE_REPLACE;
      endcase
      need = min_body_length(3'(kind_pick));
      if (roll < 5) begin
         do type_byte = 8'($urandom_range(0, 255)); while (kind_of_type(type_byte) >= 0);
         length = 16'($urandom_range(0, 65535));
         broken = 1'b1;
      end else if (roll < 12) begin
         length = 16'($urandom_range(0, need - 1));
         broken = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         length = need + 16'($urandom_range(4, 24));
      end else begin
         length = need + 16'($urandom_range(0, 3));
      end
      chunk.insert(chunk.size(), {1'b0, length[15:8]});
      chunk.insert(chunk.size(), {1'b0, length[7:0]});
      if (broken) begin
         // everything after the type byte is dropped up to end of buffer
         chunk.insert(chunk.size(), {1'b0, type_byte});
         noise = int'($urandom_range(0, 6));
         for (i = 0; i < noise; i++)
            chunk.insert(chunk.size(), {1'b0, 8'($urandom_range(0, 255))});
         chunk[chunk.size() - 1][8] = 1'b1;
      end else begin
         fill = int'($urandom_range(0, 7));
         for (i = 0; i < length; i++) begin
            case (fill)
               0:       body.insert(body.size(), 8'h00);
               1:       body.insert(body.size(), 8'hFF);
               2:       body.insert(body.size(), ompar_pkg::CHAR_SPACE);
               default: body.insert(body.size(), 8'($urandom_range(0, 255)));
            endcase
         end
         body[0] = type_byte;
         if (type_byte == ompar_pkg::TYPE_ADD) begin
            case ($urandom_range(0, 2))
               0:       body[19] = ompar_pkg::SIDE_BUY;
               1:       body[19] = SIDE_SELL;
               default: ;
            endcase
            spaces = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 8)) : 0;
            for (i = 0; i < spaces; i++) body[31 - i] = ompar_pkg::CHAR_SPACE;
         end
         for (i = 0; i < body.size(); i++) chunk.insert(chunk.size(), {1'b0, body[i]});
         if ($urandom_range(0, 11) == 0) begin
            // truncate: partial message at end of buffer
            chunk = chunk[0:$urandom_range(0, chunk.size() - 2)];
            chunk[chunk.size() - 1][8] = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            chunk[chunk.size() - 1][8] = 1'b1;
         end
      end
      for (i = 0; i < chunk.size(); i++)
         send_stream_byte(chunk[i][7:0], chunk[i][8], 1'b0, '0);
   endtask

   task automatic check_message(input ompar_pkg::rsp_item_type got);
      ompar_pkg::rsp_item_type want;
      if (expected_messages.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         fail_count++;
         return;
      end
      want = expected_messages.pop_front();
      if (got !== want) begin
         fail_count++;
         if (got.message_kind !== want.message_kind)
            $display("%0t: message_kind expected %0d actual %0d",
                     $time, want.message_kind, got.message_kind);
         if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         if (got.stamp_ns !== want.stamp_ns)
            $display("%0t: stamp_ns expected %h actual %h",
                     $time, want.stamp_ns, got.stamp_ns);
         if (got.order_ref !== want.order_ref)
            $display("%0t: order_ref expected %h actual %h",
                     $time, want.order_ref, got.order_ref);
         if (got.buy_side !== want.buy_side)
            $display("%0t: buy_side expected %b actual %b", $time, want.buy_side, got.buy_side);
         if (got.quantity !== want.quantity)
            $display("%0t: quantity expected %h actual %h",
                     $time, want.quantity, got.quantity);
         if (got.raw_price !== want.raw_price)
            $display("%0t: raw_price expected %h actual %h",
                     $time, want.raw_price, got.raw_price);
         if (got.symbol_chars !== want.symbol_chars)
            $display("%0t: symbol_chars expected %h actual %h",
                     $time, want.symbol_chars, got.symbol_chars);
      end
   endtask

   // result side: random pop gaps, bursts without gaps, one long hold-off
   initial begin : result_side
      int gap;
      int pops;
      bit rush;
      pops = 0;
      rush = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (pops % 16 == 0) rush = ($urandom_range(0, 2) == 0);
         gap = rush ? 0 : int'($urandom_range(0, 3));
         if (pops == HOLD_AT_POP) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_message(rsp_data);
         pops++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stream_side
      ompar_pkg::rsp_item_type typed_msg;
      bit                      drained_midway;
      int                      row;
      drained_midway = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (row = 0; row < TABLE_ROWS; row++) begin
         typed_msg = '0;
         typed_msg.message_kind = STIMULUS_TABLE[row].kind;
         typed_msg.status = STIMULUS_TABLE[row].status;
         send_stream_byte(STIMULUS_TABLE[row].data, STIMULUS_TABLE[row].last,
                          STIMULUS_TABLE[row].typed, typed_msg);
      end
      drain_results();
      while (byte_count < ITEM_TARGET) begin
         send_random_message();
         if (!drained_midway && byte_count > ITEM_TARGET / 2) begin
            drained_midway = 1'b1;
            drain_results();
         end
      end
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
